// ----- rtl/core/pad_button_edge_autorepeat_macros.svh -----
// Assertion macros shared by the pad button edge / auto-repeat checkers.
// Included by bare file name; holds only macro definitions.
`ifndef PAD_BUTTON_EDGE_AUTOREPEAT_MACROS_SVH
`define PAD_BUTTON_EDGE_AUTOREPEAT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBEA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pbea_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pad button edge / auto-repeat block: word types, sizes,
// register indexes and reset values. No dependencies.
package pbea_pkg;

  // Sizes
  localparam int NumPads     = 2;
  localparam int NumButtons  = 16;
  localparam int LiveButtons = (NumButtons < 16) ? NumButtons : 16;
  localparam int PadW        = (NumPads > 1) ? $clog2(NumPads) : 1;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  // Register reset values
  localparam logic [7:0] LowThrRst   = 8'h50;
  localparam logic [7:0] HighThrRst  = 8'hb0;
  localparam logic [3:0] RepDelayRst = 4'd14;
  localparam logic [3:0] RepStepRst  = 4'd6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgLowThr   = 2'd0,
    CfgHighThr  = 2'd1,
    CfgRepDelay = 2'd2,
    CfgRepStep  = 2'd3
  } pbea_cfg_idx_e;

  // Input word
  typedef struct packed {
    logic        pad_select;
    logic        comm_failed;
    logic        disconnected;
    logic [7:0]  id_byte;
    logic [15:0] buttons_raw;
    logic [7:0]  stick_right_x;
    logic [7:0]  stick_right_y;
    logic [7:0]  stick_left_x;
    logic [7:0]  stick_left_y;
  } pbea_in_t;

  // Result word
  typedef struct packed {
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] repeat_res;
    logic [3:0]  device_type;
    logic [7:0]  directions;
    logic [7:0]  direction_edges;
    logic [7:0]  out_right_x;
    logic [7:0]  out_right_y;
    logic [7:0]  out_left_x;
    logic [7:0]  out_left_y;
  } pbea_out_t;

  // Per-pad state update control
  typedef struct packed {
    logic            commit;
    logic            clear;
    logic [PadW-1:0] pad;
  } pbea_upd_t;

endpackage

// ----- rtl/core/pbea_btn_track.sv -----
`timescale 1ns / 1ps
// Button tracker: previous held word and per-button hold counters per pad,
// producing held, pressed and auto-repeat masks. Depends on pbea_pkg.
module pbea_btn_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbea_pkg::pbea_upd_t upd_i,
  input  logic [15:0]         buttons_raw_i,
  input  logic [3:0]          rep_delay_i,
  input  logic [3:0]          rep_step_i,
  output logic [15:0]         held_o,
  output logic [15:0]         pressed_o,
  output logic [15:0]         repeat_o
);

  logic [15:0] prev_held_q [pbea_pkg::NumPads];
  logic [3:0]  cnt_q [pbea_pkg::NumPads][pbea_pkg::NumButtons];
  logic [3:0]  cnt_d [pbea_pkg::NumButtons];
  logic [15:0] rpt;

  // Invert active-low buttons and find new presses
  assign held_o    = ~buttons_raw_i;
  assign pressed_o = held_o & ~prev_held_q[upd_i.pad];

  // Advance each button's counter and build the repeat mask
  always_comb begin
    rpt = '0;
    for (int j = 0; j < pbea_pkg::NumButtons; j++) begin
      cnt_d[j] = cnt_q[upd_i.pad][j];
    end
    for (int j = 0; j < pbea_pkg::LiveButtons; j++) begin
      if (held_o[j]) begin
        if (cnt_q[upd_i.pad][j] < rep_delay_i) begin
          cnt_d[j] = cnt_q[upd_i.pad][j] + 4'd1;
          rpt[j]   = pressed_o[j];
        end else begin
          cnt_d[j] = (cnt_q[upd_i.pad][j] > rep_step_i) ?
                     (cnt_q[upd_i.pad][j] - rep_step_i) : 4'd0;
          rpt[j]   = 1'b1;
        end
      end else begin
        cnt_d[j] = 4'd0;
      end
    end
  end

  assign repeat_o = rpt | pressed_o;

  // Write back the selected pad's row, or clear it on disconnect
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < pbea_pkg::NumPads; p++) begin
        prev_held_q[p] <= '0;
        for (int j = 0; j < pbea_pkg::NumButtons; j++) begin
          cnt_q[p][j] <= '0;
        end
      end
    end else if (upd_i.commit) begin
      if (upd_i.clear) begin
        prev_held_q[upd_i.pad] <= '0;
        for (int j = 0; j < pbea_pkg::NumButtons; j++) begin
          cnt_q[upd_i.pad][j] <= '0;
        end
      end else begin
        prev_held_q[upd_i.pad] <= held_o;
        for (int j = 0; j < pbea_pkg::NumButtons; j++) begin
          cnt_q[upd_i.pad][j] <= cnt_d[j];
        end
      end
    end
  end

endmodule

// ----- rtl/core/pbea_dir_track.sv -----
`timescale 1ns / 1ps
// Direction tracker: slices four stick bytes into eight direction bits and
// flags newly set ones against the pad's previous directions. Uses pbea_pkg.
module pbea_dir_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbea_pkg::pbea_upd_t upd_i,
  input  logic [7:0]          right_x_i,
  input  logic [7:0]          right_y_i,
  input  logic [7:0]          left_x_i,
  input  logic [7:0]          left_y_i,
  input  logic [7:0]          low_thr_i,
  input  logic [7:0]          high_thr_i,
  output logic [7:0]          dirs_o,
  output logic [7:0]          edges_o
);

  logic [7:0] prev_dirs_q [pbea_pkg::NumPads];

  // Up, right, down, left for one stick
  function automatic logic [3:0] slice_stick(logic [7:0] x, logic [7:0] y,
                                             logic [7:0] lo, logic [7:0] hi);
    logic [3:0] d;
    d[0] = (y <= lo);
    d[1] = (x >= hi);
    d[2] = (y >= hi);
    d[3] = (x <= lo);
    return d;
  endfunction

  assign dirs_o = {slice_stick(left_x_i, left_y_i, low_thr_i, high_thr_i),
                   slice_stick(right_x_i, right_y_i, low_thr_i, high_thr_i)};
  assign edges_o = dirs_o & ~prev_dirs_q[upd_i.pad];

  // Hold the last directions per pad; drop them on disconnect
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < pbea_pkg::NumPads; p++) begin
        prev_dirs_q[p] <= '0;
      end
    end else if (upd_i.commit) begin
      prev_dirs_q[upd_i.pad] <= upd_i.clear ? 8'd0 : dirs_o;
    end
  end

endmodule

// ----- rtl/core/pad_button_edge_autorepeat.sv -----
`timescale 1ns / 1ps
// Top level of the pad button edge / auto-repeat block: input register,
// configuration registers, trackers and result register. Uses pbea_pkg.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------
//  in      | sink      | in_valid_i / in_ready_o | pbea_in_t  in_data_i
//  out     | source    | out_valid_o/out_ready_i | pbea_out_t out_data_o
//  cfg     | sink      | cfg_we_i, no wait      | cfg_idx_i, cfg_wdata_i
//
// One word per clock unless a stalled result holds it; a word goes from the input
// register through the tracker logic into the result register.
// Pad state is read and written back in the same cycle the word leaves the
// input register, so words for the same pad can follow back to back.
// Reset clears all pad state at once; there is no clearing pass.
// A stalled result holds the input register only when that word has a result.
module pad_button_edge_autorepeat (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbea_pkg::pbea_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbea_pkg::pbea_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [pbea_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbea_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic                s1_valid_q;
  pbea_pkg::pbea_in_t  s1_q;
  logic                out_valid_q;
  pbea_pkg::pbea_out_t out_q;
  pbea_pkg::pbea_out_t out_d;

  logic [7:0] low_thr_q;
  logic [7:0] high_thr_q;
  logic [3:0] rep_delay_q;
  logic [3:0] rep_step_q;

  logic                pad_ok;
  logic                s1_has_res;
  logic                s1_go;
  pbea_pkg::pbea_upd_t upd;

  logic [15:0] held;
  logic [15:0] pressed;
  logic [15:0] rpt;
  logic [7:0]  dirs;
  logic [7:0]  dir_edges;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= pbea_pkg::LowThrRst;
      high_thr_q  <= pbea_pkg::HighThrRst;
      rep_delay_q <= pbea_pkg::RepDelayRst;
      rep_step_q  <= pbea_pkg::RepStepRst;
    end else if (cfg_we_i) begin
      case (pbea_pkg::pbea_cfg_idx_e'(cfg_idx_i))
        pbea_pkg::CfgLowThr:   low_thr_q   <= cfg_wdata_i[7:0];
        pbea_pkg::CfgHighThr:  high_thr_q  <= cfg_wdata_i[7:0];
        pbea_pkg::CfgRepDelay: rep_delay_q <= cfg_wdata_i[3:0];
        pbea_pkg::CfgRepStep:  rep_step_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Decide what the word in the input register does
  assign pad_ok     = (32'(s1_q.pad_select) < 32'(pbea_pkg::NumPads));
  assign s1_has_res = s1_valid_q && pad_ok && !s1_q.disconnected && !s1_q.comm_failed;
  assign s1_go      = s1_valid_q && (!s1_has_res || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign upd.commit = s1_go && pad_ok && (s1_q.disconnected || !s1_q.comm_failed);
  assign upd.clear  = s1_q.disconnected;
  assign upd.pad    = pbea_pkg::PadW'(s1_q.pad_select);

  pbea_btn_track u_btn_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (upd),
    .buttons_raw_i (s1_q.buttons_raw),
    .rep_delay_i   (rep_delay_q),
    .rep_step_i    (rep_step_q),
    .held_o        (held),
    .pressed_o     (pressed),
    .repeat_o      (rpt)
  );

  pbea_dir_track u_dir_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .right_x_i  (s1_q.stick_right_x),
    .right_y_i  (s1_q.stick_right_y),
    .left_x_i   (s1_q.stick_left_x),
    .left_y_i   (s1_q.stick_left_y),
    .low_thr_i  (low_thr_q),
    .high_thr_i (high_thr_q),
    .dirs_o     (dirs),
    .edges_o    (dir_edges)
  );

  // Assemble the result word
  always_comb begin
    out_d.held            = held;
    out_d.pressed         = pressed;
    out_d.repeat_res      = rpt;
    out_d.device_type     = s1_q.id_byte[7:4];
    out_d.directions      = dirs;
    out_d.direction_edges = dir_edges;
    out_d.out_right_x     = s1_q.stick_right_x;
    out_d.out_right_y     = s1_q.stick_right_y;
    out_d.out_left_x      = s1_q.stick_left_x;
    out_d.out_left_y      = s1_q.stick_left_y;
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_go && s1_has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (s1_go && s1_has_res) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/pbea_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the pad button edge / auto-repeat block, bound to
// the top level. Uses pbea_pkg and the shared assertion macros.
`include "pad_button_edge_autorepeat_macros.svh"

module pbea_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pbea_pkg::pbea_out_t out_data_o
);

  // A stalled result word stays offered
  `PBEA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result word dropped while stalled")

  // New presses are always held buttons
  `PBEA_ASSERT_IMPL(a_pressed_in_held, clk_i, rst_ni, out_valid_o, (out_data_o.pressed & ~out_data_o.held) == 16'd0, "pressed bit without held bit")

  // Every new press also shows in the repeat mask
  `PBEA_ASSERT_IMPL(a_pressed_in_rpt, clk_i, rst_ni, out_valid_o, (out_data_o.pressed & ~out_data_o.repeat_res) == 16'd0, "press missing from repeat mask")

  // Direction edges only on set directions
  `PBEA_ASSERT_IMPL(a_edge_in_dirs, clk_i, rst_ni, out_valid_o, (out_data_o.direction_edges & ~out_data_o.directions) == 8'd0, "direction edge without direction")

endmodule

bind pad_button_edge_autorepeat pbea_checker u_pbea_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pad_button_edge_autorepeat: drives controller frames and
// register writes, predicts each result word and compares it field by field.
// Depends on pbea_pkg and the block's RTL only.
module tb_top;

  localparam int InW = $bits(pbea_pkg::pbea_in_t);

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pbea_pkg::pbea_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pbea_pkg::pbea_out_t out_data;
  logic      cfg_we = 1'b0;
  pbea_pkg::pbea_cfg_idx_e cfg_idx = pbea_pkg::CfgLowThr;
  logic [pbea_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // Predictor copy of the registers and per-pad state
  logic [7:0]  thr_low = pbea_pkg::LowThrRst;
  logic [7:0]  thr_high = pbea_pkg::HighThrRst;
  logic [3:0]  rep_delay = pbea_pkg::RepDelayRst;
  logic [3:0]  rep_step = pbea_pkg::RepStepRst;
  logic [15:0] last_held [pbea_pkg::NumPads] = '{default: '0};
  logic [7:0]  last_dirs [pbea_pkg::NumPads] = '{default: '0};
  logic [3:0]  hold_cnt [pbea_pkg::NumPads][pbea_pkg::NumButtons] =
               '{default: '{default: '0}};

  pbea_pkg::pbea_out_t due_results[$];
  int          mismatches = 0;

  // Stimulus shaping
  logic [15:0] pad_buttons [pbea_pkg::NumPads] = '{default: '0};
  int          rx_mode = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  logic [15:0] rx_mask = '0;
  logic [3:0]  rx_slot = '0;

  pad_button_edge_autorepeat dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Slice one stick into up/right/down/left bits
  function automatic logic [3:0] axis_dirs(logic [7:0] x, logic [7:0] y);
    logic [3:0] d;
    d[0] = (y <= thr_low);
    d[1] = (x >= thr_high);
    d[2] = (y >= thr_high);
    d[3] = (x <= thr_low);
    return d;
  endfunction

  // Advance the pad state for one frame; return 1 when it yields a result word
  function automatic bit track_frame(input pbea_pkg::pbea_in_t w,
                                     output pbea_pkg::pbea_out_t r);
    logic [15:0] held_now;
    logic [15:0] new_press;
    logic [15:0] rep;
    logic [7:0]  dirs;
    int          p;
    r = '0;
    p = int'(w.pad_select);
    if (w.disconnected) begin
      last_held[p] = '0;
      last_dirs[p] = '0;
      for (int j = 0; j < pbea_pkg::NumButtons; j++) hold_cnt[p][j] = '0;
      return 1'b0;
    end
    if (w.comm_failed) return 1'b0;

    dirs = {axis_dirs(w.stick_left_x, w.stick_left_y),
            axis_dirs(w.stick_right_x, w.stick_right_y)};
    r.direction_edges = dirs & ~last_dirs[p];
    last_dirs[p] = dirs;

    held_now = ~w.buttons_raw;
    new_press = held_now & ~last_held[p];
    last_held[p] = held_now;

    rep = '0;
    for (int j = 0; j < pbea_pkg::LiveButtons; j++) begin
      if (held_now[j]) begin
        if (hold_cnt[p][j] < rep_delay) begin
          hold_cnt[p][j] = hold_cnt[p][j] + 4'd1;
          rep[j] = new_press[j];
        end else begin
          hold_cnt[p][j] = (hold_cnt[p][j] > rep_step) ? hold_cnt[p][j] - rep_step : 4'd0;
          rep[j] = 1'b1;
        end
      end else begin
        hold_cnt[p][j] = '0;
      end
    end

    r.held        = held_now;
    r.pressed     = new_press;
    r.repeat_res  = rep | new_press;
    r.device_type = w.id_byte[7:4];
    r.directions  = dirs;
    r.out_right_x = w.stick_right_x;
    r.out_right_y = w.stick_right_y;
    r.out_left_x  = w.stick_left_x;
    r.out_left_y  = w.stick_left_y;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    pbea_pkg::pbea_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with none expected, expected nothing, got %h",
                 $time, out_data);
      end else begin
        want = due_results.pop_front();
        check_field("held", want.held, out_data.held);
        check_field("pressed", want.pressed, out_data.pressed);
        check_field("repeat_res", want.repeat_res, out_data.repeat_res);
        check_field("device_type", want.device_type, out_data.device_type);
        check_field("directions", want.directions, out_data.directions);
        check_field("direction_edges", want.direction_edges, out_data.direction_edges);
        check_field("out_right_x", want.out_right_x, out_data.out_right_x);
        check_field("out_right_y", want.out_right_y, out_data.out_right_y);
        check_field("out_left_x", want.out_left_x, out_data.out_left_x);
        check_field("out_left_y", want.out_left_y, out_data.out_left_y);
      end
    end
  end

  // Receiver: stall on a 16-bit random mask, or hold off for a requested stretch
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (rx_slot == 0) begin
        case (rx_mode)
          0:       rx_mask = '0;
          1:       rx_mask = 16'($urandom() & $urandom() & $urandom());
          default: rx_mask = 16'($urandom() | $urandom());
        endcase
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !rx_mask[rx_slot];
      end
      rx_slot = rx_slot + 4'd1;
    end
  end

  function automatic pbea_pkg::pbea_in_t frame(bit pad, bit fail, bit disc, logic [7:0] id,
                                               logic [15:0] raw, logic [7:0] rx,
                                               logic [7:0] ry, logic [7:0] lx,
                                               logic [7:0] ly);
    pbea_pkg::pbea_in_t w;
    w.pad_select    = pad;
    w.comm_failed   = fail;
    w.disconnected  = disc;
    w.id_byte       = id;
    w.buttons_raw   = raw;
    w.stick_right_x = rx;
    w.stick_right_y = ry;
    w.stick_left_x  = lx;
    w.stick_left_y  = ly;
    return w;
  endfunction

  // Offer one word, hold it until accepted, then record its prediction
  task automatic send_word(input pbea_pkg::pbea_in_t w);
    pbea_pkg::pbea_out_t r;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    if (track_frame(w, r)) due_results.push_back(r);
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // Drop valid and wait for every result, plus the pipeline depth for dropped frames
  task automatic drain_results();
    idle_input(1);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(pbea_pkg::pbea_cfg_idx_e idx, logic [7:0] val);
    drain_results();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      pbea_pkg::CfgLowThr:   thr_low = val;
      pbea_pkg::CfgHighThr:  thr_high = val;
      pbea_pkg::CfgRepDelay: rep_delay = val[3:0];
      pbea_pkg::CfgRepStep:  rep_step = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] lo, logic [7:0] hi, logic [3:0] dly, logic [3:0] stp);
    write_reg(pbea_pkg::CfgLowThr, lo);
    write_reg(pbea_pkg::CfgHighThr, hi);
    write_reg(pbea_pkg::CfgRepDelay, {4'd0, dly});
    write_reg(pbea_pkg::CfgRepStep, {4'd0, stp});
  endtask

  // Favor values on and next to the thresholds
  function automatic logic [7:0] pick_stick();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return thr_low;
      4:       return thr_low + 8'd1;
      5:       return thr_high;
      6:       return thr_high - 8'd1;
      default: return 8'($urandom());
    endcase
  endfunction

  // Mostly well-formed frames with slowly changing buttons; some noise
  task automatic make_frame(output pbea_pkg::pbea_in_t w, output bit counted);
    int  kind;
    bit  p;
    kind = $urandom_range(99);
    p = 1'($urandom_range(1));
    if (kind < 6) begin
      w = InW'({$urandom(), $urandom()});
    end else begin
      case ($urandom_range(9))
        6, 7:    pad_buttons[p][$urandom_range(15)] ^= 1'b1;
        8: begin
          pad_buttons[p][$urandom_range(15)] ^= 1'b1;
          pad_buttons[p][$urandom_range(15)] ^= 1'b1;
        end
        9:       pad_buttons[p] = 16'($urandom() & $urandom());
        default: ;
      endcase
      w = frame(p, kind < 14, 1'b0, 8'($urandom()), ~pad_buttons[p],
                pick_stick(), pick_stick(), pick_stick(), pick_stick());
      if (kind >= 14 && kind < 18) begin
        w.disconnected = 1'b1;
        w.comm_failed  = 1'($urandom_range(1));
        pad_buttons[p] = '0;
      end
    end
    counted = w.disconnected || !w.comm_failed;
  endtask

  task automatic test_field_extremes();
    send_word(frame(0, 0, 0, 8'h00, 16'hffff, 8'h80, 8'h80, 8'h80, 8'h80));
    send_word(frame(0, 0, 0, 8'hff, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(frame(1, 0, 0, 8'h5a, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff));
    send_word(frame(1, 0, 0, 8'ha5, 16'hffff, 8'd176, 8'd80, 8'd80, 8'd176));
    send_word(frame(0, 0, 0, 8'h3c, 16'h5555, 8'd81, 8'd175, 8'd175, 8'd81));
    send_word(frame(1, 0, 0, 8'hc3, 16'haaaa, 8'd79, 8'd177, 8'd177, 8'd79));
  endtask

  task automatic test_special_cases();
    // Failed receive: no word out, state untouched
    send_word(frame(0, 1, 0, 8'hff, 16'h0000, 8'h00, 8'hff, 8'h00, 8'hff));
    send_word(frame(0, 0, 0, 8'h41, 16'h5555, 8'h80, 8'h80, 8'h80, 8'h80));
    // Disconnect clears the pad, also when the receive failed too
    send_word(frame(0, 1, 1, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(frame(0, 0, 0, 8'h73, 16'h0000, 8'h00, 8'h00, 8'hff, 8'hff));
    send_word(frame(1, 0, 1, 8'h00, 16'hffff, 8'h80, 8'h80, 8'h80, 8'h80));
    // Shortest delay and longest step: repeat each other frame, counter floors at zero
    set_config(8'd80, 8'd176, 4'd1, 4'd14);
    repeat (4) send_word(frame(1, 0, 0, 8'h10, 16'hfffe, 8'h80, 8'h80, 8'h80, 8'h80));
    // Overlapping thresholds set both directions of each axis
    set_config(8'd200, 8'd50, 4'd14, 4'd6);
    send_word(frame(0, 0, 0, 8'h20, 16'hfff0, 8'h80, 8'h80, 8'h80, 8'h80));
    send_word(frame(0, 0, 0, 8'h20, 16'hfff0, 8'd10, 8'd250, 8'd128, 8'd30));
  endtask

  task automatic test_random_traffic();
    logic [7:0] lo [8];
    logic [7:0] hi [8];
    logic [3:0] dly [8];
    logic [3:0] stp [8];
    pbea_pkg::pbea_in_t w;
    bit         counted;
    int         done_items;
    int         burst;
    lo  = '{8'd80, 8'd0, 8'd255, 8'd200, 8'd127, 8'd1, 8'd80, 8'd80};
    hi  = '{8'd176, 8'd255, 8'd0, 8'd50, 8'd128, 8'd254, 8'd176, 8'd176};
    dly = '{4'd14, 4'd15, 4'd1, 4'd3, 4'd15, 4'd1, 4'd2, 4'd7};
    stp = '{4'd6, 4'd1, 4'd14, 4'd2, 4'd14, 4'd1, 4'd1, 4'd5};
    lo[6]  = 8'($urandom());
    hi[6]  = 8'($urandom());
    dly[7] = 4'($urandom_range(15, 1));
    stp[7] = 4'($urandom_range(14, 1));
    for (int ph = 0; ph < 8; ph++) begin
      set_config(lo[ph], hi[ph], dly[ph], stp[ph]);
      rx_mode = ph % 3;
      done_items = 0;
      burst = 0;
      while (done_items < 85) begin
        // Bursts with random gaps, except in the back-to-back phases
        if (burst == 0) begin
          if (ph % 4 != 3) idle_input($urandom_range(6));
          burst = $urandom_range(16, 1);
        end
        make_frame(w, counted);
        send_word(w);
        burst--;
        if (counted) done_items++;
      end
    end
    rx_mode = 0;
  endtask

  task automatic test_backpressure();
    pbea_pkg::pbea_in_t w;
    bit       counted;
    rx_mode = 0;
    hold_req = 80;
    // Keep offering while the receiver is held off so the input stalls
    repeat (24) begin
      make_frame(w, counted);
      send_word(w);
    end
    // Pause until every result is back, then resume under heavy stalls
    drain_results();
    rx_mode = 2;
    repeat (24) begin
      make_frame(w, counted);
      send_word(w);
    end
    rx_mode = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_special_cases();
    test_random_traffic();
    test_backpressure();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pbea_pkg.sv
rtl/core/pbea_btn_track.sv
rtl/core/pbea_dir_track.sv
rtl/core/pad_button_edge_autorepeat.sv
rtl/core/pbea_checker.sv
tb/sv/tb_top.sv
